// ===== hw/rtl/hld_pkg.sv =====
// ----------------------------------------------------------------------------
// hld_pkg: shared definitions of the header/length deframer
// Register indexes, fixed field widths and the window control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package hld_pkg;

  // default depth of the sync header, in bytes (1..16)
  localparam int HEADER_BYTES_DEF = 16;

  // length field size in bytes (1..4) and its byte counter width
  localparam int LENGTH_BYTES = 4;
  localparam int LEN_CNT_W    = 2;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_UPPER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_LOWER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_BIG_END = 2'd2;

  // control from the frame sequencer to the window cells
  typedef struct packed {
    logic shift;   // take the neighbor's byte this cycle
    logic clear;   // header found: wipe the window
  } win_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hld_channels_if.sv =====
// ----------------------------------------------------------------------------
// hld channel interfaces
// Valid/ready channels for received bytes, payload results and config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface hld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_last;
  logic       frame_empty;

  modport source (output valid, output payload_byte, output frame_last,
                  output frame_empty, input ready);
  modport sink   (input valid, input payload_byte, input frame_last,
                  input frame_empty, output ready);
endinterface

interface hld_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/header_length_deframer_top.sv =====
// ----------------------------------------------------------------------------
// header_length_deframer_top: sync header / length prefixed byte deframer
// ----------------------------------------------------------------------------
// Accepts one received byte per clock and gives zero or one result beat per
// byte in the cycle after it is taken; a finished beat waiting on the output
// does not stop the next byte unless the output is stalled.
// While hunting, each byte slides into a chain of window cells holding the
// newest HEADER_BYTES-1 bytes; together with the incoming byte they compare
// in parallel with the final HEADER_BYTES bytes of the
// configured 16-byte sync header; on a hit the window is wiped, then
// LENGTH_BYTES length bytes (order set by length_big_endian) are gathered
// and that many payload bytes pass out, the last one marked. A length of zero
// gives a single beat flagged empty. The one-byte-per-cycle rate is set by
// the combinational window compare and the 32-bit payload down-counter.
// Configuration writes are always taken; an index past the register list
// is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_deframer_top
  import hld_pkg::*;
#(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  hld_in_if.sink    in_ch,
  hld_out_if.source out_ch,
  hld_cfg_if.sink   cfg_ch
);

  logic [CFG_DATA_W-1:0] hdr_upper_r;
  logic [CFG_DATA_W-1:0] hdr_lower_r;
  logic                  len_big_end_r;

  logic [2*CFG_DATA_W-1:0] hdr_cat;
  logic [BYTE_W-1:0]       link [HEADER_BYTES];
  logic [HEADER_BYTES-1:0] cell_match;
  win_ctrl_t               win_ctrl;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_upper_r   <= '0;
      hdr_lower_r   <= '0;
      len_big_end_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HDR_UPPER:   hdr_upper_r   <= cfg_ch.data;
        CFG_HDR_LOWER:   hdr_lower_r   <= cfg_ch.data;
        CFG_LEN_BIG_END: len_big_end_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // header byte 0 sits in the top bits; the last byte in the bottom bits
  assign hdr_cat = {hdr_upper_r, hdr_lower_r};

  // window chain: newest byte enters the top cell, link 0 is the oldest byte
  assign link[HEADER_BYTES-1] = in_ch.data_byte;

  for (genvar j = 1; j < HEADER_BYTES; j++) begin : g_cell
    hld_window_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (win_ctrl),
      .byte_in   (link[j]),
      .sync_byte (hdr_cat[BYTE_W*(HEADER_BYTES-1-j) +: BYTE_W]),
      .byte_out  (link[j-1]),
      .match     (cell_match[j])
    );
  end

  // oldest compared byte drops out on the next shift, so it needs no storage
  assign cell_match[0] = (link[0] == hdr_cat[BYTE_W*(HEADER_BYTES-1) +: BYTE_W]);

  // frame sequencer and result register
  hld_frame_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .data_byte      (in_ch.data_byte),
    .hdr_match      (&cell_match),
    .len_big_endian (len_big_end_r),
    .win_ctrl       (win_ctrl),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .payload_byte   (out_ch.payload_byte),
    .frame_last     (out_ch.frame_last),
    .frame_empty    (out_ch.frame_empty)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/hld_window_cell.sv =====
// ----------------------------------------------------------------------------
// hld_window_cell: one byte of the sliding header window
// Holds a byte, passes it to its older neighbor and flags whether the byte
// it is about to take equals its sync header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hld_window_cell
  import hld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire win_ctrl_t         ctrl,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic [BYTE_W-1:0] sync_byte,
  output logic      [BYTE_W-1:0] byte_out,
  output logic                   match
);

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] win_nxt;

  // compare the byte that shifts in, so the match reflects the new window
  assign match    = (byte_in == sync_byte);
  assign byte_out = win_r;

  always_comb begin
    win_nxt = win_r;
    if (ctrl.clear) begin
      win_nxt = '0;
    end else if (ctrl.shift) begin
      win_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hld_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// hld_frame_ctrl: frame sequencer and result register
// Tracks hunt/length/payload phase, assembles the length field, counts the
// payload down and registers at most one result beat per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hld_frame_ctrl
  import hld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              hdr_match,
  input  wire logic              len_big_endian,
  output win_ctrl_t              win_ctrl,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] payload_byte,
  output logic                   frame_last,
  output logic                   frame_empty
);

  // phase codes; the unused code behaves as hunting
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [LEN_CNT_W-1:0] LEN_CNT_LAST = LEN_CNT_W'(LENGTH_BYTES - 1);

  logic [1:0]           phase_r,  phase_nxt;
  logic [LEN_CNT_W-1:0] len_cnt_r, len_cnt_nxt;
  logic [LEN_W-1:0]     len_acc_r, len_acc_nxt;
  logic [LEN_W-1:0]     remain_r,  remain_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r,  out_byte_nxt;
  logic                 out_last_r,  out_last_nxt;
  logic                 out_empty_r, out_empty_nxt;

  logic             in_beat;
  logic [LEN_W-1:0] len_shifted;
  logic [LEN_W-1:0] remain_dec;

  // a new byte is taken whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign in_beat  = in_valid && in_ready;

  assign len_shifted = LEN_W'(data_byte) << {len_cnt_r, 3'b000};
  assign remain_dec  = remain_r - LEN_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    len_cnt_nxt   = len_cnt_r;
    len_acc_nxt   = len_acc_r;
    remain_nxt    = remain_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    win_ctrl      = '0;
    // result beat leaves when the sink takes it
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_beat) begin
      case (phase_r)
        PH_LENGTH: begin
          if (len_big_endian) begin
            len_acc_nxt = {len_acc_r[LEN_W-BYTE_W-1:0], data_byte};
          end else begin
            len_acc_nxt = len_acc_r | len_shifted;
          end
          if (len_cnt_r == LEN_CNT_LAST) begin
            len_cnt_nxt = '0;
            remain_nxt  = len_acc_nxt;
            len_acc_nxt = '0;
            if (remain_nxt == '0) begin
              // empty frame: a single flagged beat
              phase_nxt     = PH_HUNT;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_last_nxt  = 1'b1;
              out_empty_nxt = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            len_cnt_nxt = len_cnt_r + LEN_CNT_W'(1);
          end
        end
        PH_PAYLOAD: begin
          remain_nxt    = remain_dec;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_byte;
          out_last_nxt  = (remain_dec == '0);
          out_empty_nxt = 1'b0;
          if (remain_dec == '0) begin
            phase_nxt = PH_HUNT;
          end
        end
        default: begin
          // hunting: slide the window, start a frame on a header hit
          phase_nxt      = PH_HUNT;
          win_ctrl.shift = 1'b1;
          if (hdr_match) begin
            win_ctrl.clear = 1'b1;
            phase_nxt      = PH_LENGTH;
            len_cnt_nxt    = '0;
            len_acc_nxt    = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      len_cnt_r   <= '0;
      len_acc_r   <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_cnt_r   <= len_cnt_nxt;
      len_acc_r   <= len_acc_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_valid    = out_valid_r;
  assign payload_byte = out_byte_r;
  assign frame_last   = out_last_r;
  assign frame_empty  = out_empty_r;

endmodule

`default_nettype wire

// ===== dv/tb_header_length_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_header_length_deframer_top: self-checking bench of the deframer
// Streams received bytes under several sync header and length byte order
// settings: a short directed stretch, then mostly well-formed frames with
// random content mixed with noise and broken headers. Every result beat is
// compared with a local byte-level deframer model. Both channels idle in
// random bursts except in the final stretch.
// ----------------------------------------------------------------------------
module tb_header_length_deframer_top
  import hld_pkg::*;
();

  localparam int HDR_N          = HEADER_BYTES_DEF;
  localparam int SETTLE_CYCLES  = 4;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_BUDGET   = 130;
  localparam int TAIL_PAYLOAD   = 150;

  // register index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // window compare mask over the newest HDR_N bytes
  localparam logic [127:0] HDR_MASK =
    (HDR_N >= 16) ? {128{1'b1}} : ((128'd1 << (8 * HDR_N)) - 128'd1);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } deframe_phase_t;

  // deframer state plus its register copy; newest window byte in bits 7..0
  typedef struct packed {
    logic [127:0]        window;
    deframe_phase_t      phase;
    logic [LEN_CNT_W-1:0] len_cnt;
    logic [LEN_W-1:0]    len_acc;
    logic [LEN_W-1:0]    remaining;
    logic [63:0]         hdr_upper;
    logic [63:0]         hdr_lower;
    logic                big_end;
  } deframer_view_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              frame_empty;
  } frame_beat_t;

  logic clk;
  logic rst_n;

  hld_in_if  in_bus ();
  hld_out_if out_bus ();
  hld_cfg_if cfg_bus ();

  header_length_deframer_top #(
    .HEADER_BYTES(HDR_N)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  deframer_view_t    dut_view;        // tracks the block at each accepted beat
  deframer_view_t    plan_view;       // tracks the stream as it is generated
  logic [BYTE_W-1:0] pending_bytes[$];
  frame_beat_t       expected_beats[$];
  int                planned_items;
  int                fail_cnt;
  int                cycle_cnt;
  bit                idle_on;
  int                in_gap;
  int                out_gap;
  bit                in_held;
  bit                drv_has_beat;
  frame_beat_t       drv_beat;
  frame_beat_t       mon_beat;

  // --------------------------------------------------------------------------
  // deframer model
  // --------------------------------------------------------------------------
  function automatic deframer_view_t reset_view();
    deframer_view_t v;
    v = '0;
    v.phase   = PH_HUNT;
    v.big_end = 1'b1;
    return v;
  endfunction

  function automatic void apply_reg(inout deframer_view_t v,
                                    input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_HDR_UPPER:   v.hdr_upper = val;
      CFG_HDR_LOWER:   v.hdr_lower = val;
      CFG_LEN_BIG_END: v.big_end   = val[0];
      default: ;
    endcase
  endfunction

  // one received byte in, returns 1 when it yields a result beat
  function automatic bit deframe_byte(inout deframer_view_t v,
                                      input logic [BYTE_W-1:0] b,
                                      output frame_beat_t beat);
    bit got;
    int cnt;
    got  = 1'b0;
    beat = '0;
    case (v.phase)
      PH_LENGTH: begin
        cnt = int'(v.len_cnt);
        if (v.big_end) begin
          v.len_acc = {v.len_acc[LEN_W-9:0], b};
        end else begin
          v.len_acc = v.len_acc | ({{(LEN_W-8){1'b0}}, b} << (8 * cnt));
        end
        if (cnt + 1 >= LENGTH_BYTES) begin
          v.len_cnt = '0;
          if (v.len_acc == '0) begin
            // zero-length frame: one empty beat
            v.phase          = PH_HUNT;
            beat.frame_last  = 1'b1;
            beat.frame_empty = 1'b1;
            got              = 1'b1;
          end else begin
            v.remaining = v.len_acc;
            v.len_acc   = '0;
            v.phase     = PH_PAYLOAD;
          end
        end else begin
          v.len_cnt = LEN_CNT_W'(cnt + 1);
        end
      end
      PH_PAYLOAD: begin
        v.remaining       = v.remaining - 1'b1;
        beat.payload_byte = b;
        beat.frame_last   = (v.remaining == '0);
        got               = 1'b1;
        if (v.remaining == '0) v.phase = PH_HUNT;
      end
      default: begin
        // hunting: slide the byte in and compare the newest header bytes
        v.window = {v.window[119:0], b};
        v.phase  = PH_HUNT;
        if (((v.window ^ {v.hdr_upper, v.hdr_lower}) & HDR_MASK) == '0) begin
          v.window  = '0;
          v.phase   = PH_LENGTH;
          v.len_cnt = '0;
          v.len_acc = '0;
        end
      end
    endcase
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // stream generation, kept in step with plan_view
  // --------------------------------------------------------------------------
  task automatic put_byte(input logic [BYTE_W-1:0] b, input bit counts);
    frame_beat_t unused_beat;
    void'(deframe_byte(plan_view, b, unused_beat));
    pending_bytes = {pending_bytes, b};
    planned_items += int'(counts);
  endtask

  function automatic int rand_frame_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 0;
    if (pick < 90) return $urandom_range(1, 24);
    return $urandom_range(25, 300);
  endfunction

  // header bytes until the window matches (may hit early on overlap)
  task automatic send_header();
    logic [127:0] hdr;
    int           k;
    hdr = {plan_view.hdr_upper, plan_view.hdr_lower};
    for (k = 16 - HDR_N; k < 16 && plan_view.phase == PH_HUNT; k++) begin
      put_byte(hdr[127 - 8 * k -: 8], 1'b1);
    end
  endtask

  // length field in the current byte order, then up to max_pay payload bytes
  task automatic send_body(input logic [LEN_W-1:0] len, input int max_pay);
    int k;
    int n;
    for (k = 0; k < LENGTH_BYTES; k++) begin
      if (plan_view.big_end) put_byte(len[8 * (LENGTH_BYTES - 1 - k) +: 8], 1'b1);
      else                   put_byte(len[8 * k +: 8], 1'b1);
    end
    n = 0;
    while (plan_view.phase == PH_PAYLOAD && n < max_pay) begin
      put_byte(8'($urandom), 1'b1);
      n++;
    end
  endtask

  task automatic send_frame(input int len);
    send_header();
    if (plan_view.phase == PH_LENGTH) send_body(LEN_W'(len), 400);
  endtask

  // a stray byte that happened to complete a header still gets a sane frame
  task automatic recover_frame();
    if (plan_view.phase == PH_LENGTH) send_body(LEN_W'(rand_frame_len()), 400);
  endtask

  task automatic send_noise(input int n);
    repeat (n) begin
      put_byte(8'($urandom), 1'b0);
      recover_frame();
    end
  endtask

  // header prefix followed by one corrupted byte
  task automatic send_broken();
    logic [127:0] hdr;
    int           k;
    int           m;
    hdr = {plan_view.hdr_upper, plan_view.hdr_lower};
    m   = $urandom_range(1, (HDR_N > 1) ? HDR_N - 1 : 1);
    k   = 16 - HDR_N;
    while (k < 16 - HDR_N + m - 1 && plan_view.phase == PH_HUNT) begin
      put_byte(hdr[127 - 8 * k -: 8], 1'b0);
      k++;
    end
    if (plan_view.phase == PH_HUNT) begin
      put_byte(hdr[127 - 8 * k -: 8] ^ (8'd1 << $urandom_range(0, 7)), 1'b0);
    end
    recover_frame();
  endtask

  task automatic run_random(input int budget);
    int start;
    int pick;
    start = planned_items;
    while (planned_items - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 4));
        send_frame(rand_frame_len());
      end else if (pick < 85) begin
        send_broken();
      end else begin
        send_noise($urandom_range(1, 10));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // phase control
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    apply_reg(dut_view, idx, val);
    apply_reg(plan_view, idx, val);
  endtask

  task automatic set_regs(input logic [63:0] upper, input logic [63:0] lower,
                          input logic big);
    write_reg(CFG_HDR_UPPER, upper);
    write_reg(CFG_HDR_LOWER, lower);
    write_reg(CFG_LEN_BIG_END, {63'd0, big});
  endtask

  // all bytes sent, all beats back, then a settling wait for the pipeline;
  // sampled mid-cycle so the driver and monitor updates have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_bus.valid || expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // clock, reset, known input values
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    dut_view          = reset_view();
    plan_view         = reset_view();
    planned_items     = 0;
    fail_cnt          = 0;
    cycle_cnt         = 0;
    idle_on           = 1'b1;
    in_gap            = 0;
    out_gap           = 0;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: all-zero header matches on the first zero byte
    send_frame(0);
    send_header();
    send_body(LEN_W'(3), 0);
    put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b1);
    put_byte(8'h80, 1'b1);
    wait_idle();
    // out-of-range index must leave the header alone
    write_reg(CFG_IDX_UNUSED, {CFG_DATA_W{1'b1}});
    send_frame(1);
    wait_idle();

    set_regs({64{1'b1}}, {64{1'b1}}, 1'b0);
    run_random(PHASE_BUDGET);
    wait_idle();

    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    run_random(PHASE_BUDGET);
    // stop halfway through a length field, flip the byte order mid-frame
    send_header();
    put_byte(8'h00, 1'b1);
    put_byte(8'h07, 1'b1);
    wait_idle();
    write_reg(CFG_LEN_BIG_END, 64'd0);
    put_byte(8'h00, 1'b1);
    put_byte(8'h00, 1'b1);
    while (plan_view.phase == PH_PAYLOAD) put_byte(8'($urandom), 1'b1);
    wait_idle();

    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    write_reg(CFG_IDX_UNUSED, {$urandom, $urandom});
    run_random(PHASE_BUDGET);
    wait_idle();

    // zero-heavy header: a cleared window already holds most of it
    set_regs(64'd0, 64'd1, 1'b1);
    run_random(PHASE_BUDGET);
    wait_idle();

    set_regs({$urandom, $urandom}, 64'd0, 1'b1);
    run_random(PHASE_BUDGET);
    wait_idle();

    set_regs({64{1'b1}}, 64'd0, 1'b0);
    run_random(PHASE_BUDGET);
    wait_idle();

    set_regs({$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
    run_random(PHASE_BUDGET);
    wait_idle();

    // tail at full rate: a frame with a huge length that never finishes
    idle_on = 1'b0;
    send_header();
    send_body(LEN_W'($urandom) | 32'h8000_0100, TAIL_PAYLOAD);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // input driver: one beat per handshake, random idle bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        drv_has_beat = deframe_byte(dut_view, in_bus.data_byte, drv_beat);
        if (drv_has_beat) expected_beats = {expected_beats, drv_beat};
        in_held = 1'b0;
      end else begin
        in_held = in_bus.valid;
      end
      if (!in_held) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(0, 8);
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= pending_bytes.pop_front();
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // result monitor: check each beat, stall in random bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: payload_byte %0h frame_last %0b frame_empty %0b",
                 out_bus.payload_byte, out_bus.frame_last, out_bus.frame_empty);
          fail_cnt++;
        end else begin
          mon_beat = expected_beats.pop_front();
          if (out_bus.payload_byte !== mon_beat.payload_byte) begin
            $error("payload_byte mismatch: expected %0h, actual %0h",
                   mon_beat.payload_byte, out_bus.payload_byte);
            fail_cnt++;
          end
          if (out_bus.frame_last !== mon_beat.frame_last) begin
            $error("frame_last mismatch: expected %0b, actual %0b",
                   mon_beat.frame_last, out_bus.frame_last);
            fail_cnt++;
          end
          if (out_bus.frame_empty !== mon_beat.frame_empty) begin
            $error("frame_empty mismatch: expected %0b, actual %0b",
                   mon_beat.frame_empty, out_bus.frame_empty);
            fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 8);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
